// File: hdl/exposure_countdown_controller_top_defines.svh
// Assertion macros for the exposure countdown controller RTL.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef EXPOSURE_COUNTDOWN_CONTROLLER_TOP_DEFINES_SVH
`define EXPOSURE_COUNTDOWN_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define ECC_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define ECC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/ecc_pkg.sv
// Shared types and constants for the exposure countdown controller.
// No dependencies; compiled first.
`default_nettype none

package ecc_pkg;

   localparam int CMD_W       = 3;
   localparam int MODE_W      = 3;
   localparam int MINSEC_W    = 6;
   localparam int STEP_W      = 8;
   localparam int MAXSEC_W    = 12;
   localparam int PRESS_W     = 3;
   localparam int REM_W       = 12;   // seconds within one hour, below 3600
   localparam int QUOT_W      = 5;    // whole hours in a 16-bit time, at most 18
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;

   // floor(2^28 / 3600): under-estimates the hour count by at most one for
   // any time below 2^16, fixed by one compare and subtract
   localparam int HOUR_RECIP       = 74565;
   localparam int HOUR_RECIP_W     = 17;
   localparam int HOUR_RECIP_SHIFT = 28;

   // ceil(2^17 / 60): exact for any value below 3600
   localparam int MIN_RECIP       = 2185;
   localparam int MIN_RECIP_W     = 12;
   localparam int MIN_RECIP_SHIFT = 17;

   localparam logic [STEP_W-1:0]   STEP_SECONDS_RST  = 8'd5;
   localparam logic [MAXSEC_W-1:0] MAX_SECONDS_RST   = 12'd3595;
   localparam logic [PRESS_W-1:0]  SPECIAL_PRESS_RST = 3'd5;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 3'd0,
      CMD_EDIT  = 3'd1,
      CMD_START = 3'd2,
      CMD_STOP  = 3'd3,
      CMD_STEP  = 3'd4
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEP_SECONDS  = 2'd0,
      CSR_MAX_SECONDS   = 2'd1,
      CSR_SPECIAL_PRESS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [STEP_W-1:0]   step_seconds;
      logic [MAXSEC_W-1:0] max_seconds;
      logic [PRESS_W-1:0]  special_press_count;
   } cfg_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              led_on;
      logic              blink_active;
      logic              done_pulse;
      logic              special_pulse;
   } flags_type;

endpackage

`default_nettype wire

// File: hdl/ecc_if.sv
// Valid/ready channel interfaces for event items and result items.
// Depends on ecc_pkg for field widths.
`default_nettype none

interface ecc_req_if;
   logic                      valid;
   logic                      ready;
   logic [ecc_pkg::CMD_W-1:0] cmd;
   logic                      step_up;

   modport source (output valid, output cmd, output step_up, input ready);
   modport sink   (input valid, input cmd, input step_up, output ready);
endinterface

interface ecc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ecc_pkg::MODE_W-1:0]   mode;
   logic                         led_on;
   logic                         blink_active;
   logic [ecc_pkg::MINSEC_W-1:0] shown_minutes;
   logic [ecc_pkg::MINSEC_W-1:0] shown_seconds;
   logic                         done_pulse;
   logic                         special_pulse;

   modport source (output valid, output mode, output led_on, output blink_active,
                   output shown_minutes, output shown_seconds, output done_pulse,
                   output special_pulse, input ready);
   modport sink   (input valid, input mode, input led_on, input blink_active,
                   input shown_minutes, input shown_seconds, input done_pulse,
                   input special_pulse, output ready);
endinterface

`default_nettype wire

// File: hdl/exposure_countdown_controller_top.sv
// Top level of the exposure countdown controller: channels, config registers
// and pipeline control. Depends on ecc_pkg, ecc_if, ecc_core, ecc_hour_rem, ecc_minsec.
//
//   channel    | direction | carries
//   -----------+-----------+----------------------------------------------
//   req_chan   | in        | event item: cmd, step_up
//   rsp_chan   | out       | result item: mode, lamps, minutes, seconds, pulses
//   csr_*      | in        | register writes, no read-back
//
// One item per cycle sustained while rsp_chan is ready; a result passes the input
// register, state update, hour remainder and minute split after its item is taken.
// Reset is synchronous: mode idle, times and press count zero, registers at
// their defaults; no memory to clear.
// A stalled rsp_chan holds its item; up to four items queue in the pipeline
// before req_chan.ready drops.
`default_nettype none

module exposure_countdown_controller_top #(
   parameter int TIME_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   ecc_req_if.sink                               req_chan,
   ecc_rsp_if.source                             rsp_chan,
   input  logic                                  csr_write_en,
   input  logic [ecc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ecc_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import ecc_pkg::*;

   cfg_type               cfg_ff;

   logic                  in_valid_ff;
   logic [CMD_W-1:0]      cmd_ff;
   logic                  step_up_ff;
   logic                  core_valid_ff;
   logic                  rem_valid_ff;
   logic                  out_valid_ff;

   logic                  in_ready;
   logic                  core_ready;
   logic                  rem_ready;
   logic                  out_ready;

   flags_type             core_flags;
   logic [TIME_BITS-1:0]  core_shown;
   flags_type             rem_flags;
   logic [REM_W-1:0]      rem_secs;
   flags_type             out_flags;
   logic [MINSEC_W-1:0]   out_minutes;
   logic [MINSEC_W-1:0]   out_seconds;

   // a stage takes a new item when empty or when its item moves on
   assign out_ready  = !out_valid_ff  || rsp_chan.ready;
   assign rem_ready  = !rem_valid_ff  || out_ready;
   assign core_ready = !core_valid_ff || rem_ready;
   assign in_ready   = !in_valid_ff   || core_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_seconds        <= STEP_SECONDS_RST;
         cfg_ff.max_seconds         <= MAX_SECONDS_RST;
         cfg_ff.special_press_count <= SPECIAL_PRESS_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_STEP_SECONDS:  cfg_ff.step_seconds        <= csr_wdata[STEP_W-1:0];
            CSR_MAX_SECONDS:   cfg_ff.max_seconds         <= csr_wdata[MAXSEC_W-1:0];
            CSR_SPECIAL_PRESS: cfg_ff.special_press_count <= csr_wdata[PRESS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         core_valid_ff <= 1'b0;
         rem_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (core_ready) begin
            core_valid_ff <= in_valid_ff;
         end
         if (rem_ready) begin
            rem_valid_ff <= core_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= rem_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_chan.valid) begin
         cmd_ff     <= req_chan.cmd;
         step_up_ff <= req_chan.step_up;
      end
   end

   ecc_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .load    (in_valid_ff && core_ready),
      .cmd     (cmd_ff),
      .step_up (step_up_ff),
      .cfg     (cfg_ff),
      .flags   (core_flags),
      .shown   (core_shown)
   );

   ecc_hour_rem #(
      .TIME_BITS (TIME_BITS)
   ) u_hour_rem (
      .clock     (clock),
      .load      (core_valid_ff && rem_ready),
      .shown     (core_shown),
      .flags     (core_flags),
      .rem       (rem_secs),
      .flags_out (rem_flags)
   );

   ecc_minsec u_minsec (
      .clock     (clock),
      .load      (rem_valid_ff && out_ready),
      .rem       (rem_secs),
      .flags     (rem_flags),
      .minutes   (out_minutes),
      .seconds   (out_seconds),
      .flags_out (out_flags)
   );

   assign req_chan.ready         = in_ready;
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.mode          = out_flags.mode;
   assign rsp_chan.led_on        = out_flags.led_on;
   assign rsp_chan.blink_active  = out_flags.blink_active;
   assign rsp_chan.shown_minutes = out_minutes;
   assign rsp_chan.shown_seconds = out_seconds;
   assign rsp_chan.done_pulse    = out_flags.done_pulse;
   assign rsp_chan.special_pulse = out_flags.special_pulse;

endmodule

`default_nettype wire

// File: hdl/ecc_core.sv
// Mode state machine, set time, elapsed count and stop-press counter.
// Registers the flags and shown time of each item; depends on ecc_pkg.
`default_nettype none
`include "exposure_countdown_controller_top_defines.svh"

module ecc_core #(
   parameter int TIME_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [ecc_pkg::CMD_W-1:0]     cmd,
   input  logic                          step_up,
   input  ecc_pkg::cfg_type              cfg,
   output ecc_pkg::flags_type            flags,
   output logic [TIME_BITS-1:0]          shown
);
   import ecc_pkg::*;

   localparam int LIM_W = (TIME_BITS > MAXSEC_W) ? TIME_BITS : MAXSEC_W;
   localparam logic [LIM_W-1:0] TIME_MAX = LIM_W'((2 ** TIME_BITS) - 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_IDLE  = 3'd0,
      MODE_EDIT  = 3'd1,
      MODE_SET   = 3'd2,
      MODE_RUN   = 3'd3,
      MODE_PAUSE = 3'd4
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [TIME_BITS-1:0]   set_time_ff, set_time_in;
   logic [TIME_BITS-1:0]   elapsed_ff, elapsed_in;
   logic [PRESS_W-1:0]     stop_cnt_ff, stop_cnt_in;
   flags_type              flags_ff, flags_in;
   logic [TIME_BITS-1:0]   shown_ff, shown_in;

   logic [LIM_W-1:0]       max_ext;
   logic [TIME_BITS-1:0]   limit;
   logic [TIME_BITS-1:0]   step_ext;
   logic [TIME_BITS:0]     up_sum;
   logic [TIME_BITS-1:0]   up_time;
   logic [TIME_BITS-1:0]   down_time;
   logic [TIME_BITS-1:0]   elapsed_inc;
   logic [PRESS_W-1:0]     stop_cnt_inc;
   logic                   done;
   logic                   special;

   assign max_ext      = LIM_W'(cfg.max_seconds);
   assign limit        = (max_ext < TIME_MAX) ? TIME_BITS'(max_ext) : TIME_BITS'(TIME_MAX);
   assign step_ext     = TIME_BITS'(cfg.step_seconds);
   assign up_sum       = {1'b0, set_time_ff} + {1'b0, step_ext};
   // a lowered limit pulls a larger set time down on the next increase
   assign up_time      = (up_sum < {1'b0, limit}) ? up_sum[TIME_BITS-1:0] : limit;
   assign down_time    = (set_time_ff >= step_ext) ? set_time_ff - step_ext : '0;
   assign elapsed_inc  = elapsed_ff + TIME_BITS'(1);
   assign stop_cnt_inc = stop_cnt_ff + PRESS_W'(1);

   always_comb begin
      mode_in     = mode_ff;
      set_time_in = set_time_ff;
      elapsed_in  = elapsed_ff;
      stop_cnt_in = stop_cnt_ff;
      done        = 1'b0;
      special     = 1'b0;
      case (cmd)
         CMD_TICK: begin
            if (mode_ff == MODE_RUN) begin
               elapsed_in = elapsed_inc;
               if (elapsed_inc >= set_time_ff) begin
                  done        = 1'b1;
                  mode_in     = MODE_IDLE;
                  set_time_in = '0;
                  elapsed_in  = '0;
               end
            end
         end
         CMD_EDIT: begin
            case (mode_ff)
               MODE_IDLE, MODE_SET, MODE_PAUSE: begin
                  mode_in = MODE_EDIT;
               end
               MODE_EDIT: begin
                  if (set_time_ff == '0) begin
                     mode_in     = MODE_IDLE;
                     set_time_in = '0;
                     elapsed_in  = '0;
                  end else begin
                     mode_in = MODE_SET;
                  end
               end
               default: begin
               end
            endcase
         end
         CMD_START: begin
            if (mode_ff == MODE_SET || mode_ff == MODE_PAUSE) begin
               mode_in    = MODE_RUN;
               elapsed_in = '0;   // resuming restarts the full count
            end
         end
         CMD_STOP: begin
            if (mode_ff == MODE_IDLE) begin
               // count of zero fires when the counter wraps
               stop_cnt_in = stop_cnt_inc;
               if (stop_cnt_inc == cfg.special_press_count) begin
                  stop_cnt_in = '0;
                  special     = 1'b1;
                  set_time_in = '0;
                  elapsed_in  = '0;
               end
            end else if (mode_ff == MODE_RUN) begin
               mode_in = MODE_PAUSE;
            end else begin
               mode_in     = MODE_IDLE;
               set_time_in = '0;
               elapsed_in  = '0;
            end
         end
         CMD_STEP: begin
            if (mode_ff == MODE_EDIT) begin
               set_time_in = step_up ? up_time : down_time;
            end
         end
         default: begin
         end
      endcase

      if (mode_in == MODE_RUN || mode_in == MODE_PAUSE) begin
         shown_in = (elapsed_in <= set_time_in) ? set_time_in - elapsed_in : '0;
      end else begin
         shown_in = set_time_in;
      end

      flags_in.mode          = mode_in;
      flags_in.led_on        = (mode_in == MODE_RUN);
      flags_in.blink_active  = (mode_in == MODE_EDIT);
      flags_in.done_pulse    = done;
      flags_in.special_pulse = special;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         set_time_ff <= '0;
         elapsed_ff  <= '0;
         stop_cnt_ff <= '0;
         flags_ff    <= '0;
         shown_ff    <= '0;
      end else if (load) begin
         mode_ff     <= mode_in;
         set_time_ff <= set_time_in;
         elapsed_ff  <= elapsed_in;
         stop_cnt_ff <= stop_cnt_in;
         flags_ff    <= flags_in;
         shown_ff    <= shown_in;
      end
   end

   assign flags = flags_ff;
   assign shown = shown_ff;

   `ECC_ASSERT_IMP(a_idle_clear, mode_ff == MODE_IDLE, set_time_ff == '0 && elapsed_ff == '0, "idle with time left")
   `ECC_ASSERT_NEXT(a_hold_state, !reset && !load, $stable(mode_ff) && $stable(set_time_ff) && $stable(elapsed_ff) && $stable(stop_cnt_ff), "state moved without an item")
   `ECC_ASSERT_IMP(a_done_idle, load && flags_in.done_pulse, mode_in == MODE_IDLE && mode_ff == MODE_RUN, "done outside a running count")
   `ECC_ASSERT_IMP(a_special_cnt, load && flags_in.special_pulse, stop_cnt_in == '0 && mode_ff == MODE_IDLE, "special pulse left a count")

endmodule

`default_nettype wire

// File: hdl/ecc_hour_rem.sv
// Pipeline stage: shown time modulo one hour by reciprocal multiply.
// Depends on ecc_pkg; valid for times below 2^16.
`default_nettype none

module ecc_hour_rem #(
   parameter int TIME_BITS = 12
) (
   input  logic                        clock,
   input  logic                        load,
   input  logic [TIME_BITS-1:0]        shown,
   input  ecc_pkg::flags_type          flags,
   output logic [ecc_pkg::REM_W-1:0]   rem,
   output ecc_pkg::flags_type          flags_out
);
   import ecc_pkg::*;

   localparam int PROD_W = TIME_BITS + HOUR_RECIP_W;
   localparam int MUL_W  = QUOT_W + REM_W;

   logic [PROD_W-1:0]   prod;
   logic [PROD_W-1:0]   quot_full;
   logic [QUOT_W-1:0]   quot;
   logic [MUL_W-1:0]    quot_ext;
   logic [MUL_W-1:0]    hours_secs;
   logic [MUL_W-1:0]    rem_raw;
   logic [MUL_W-1:0]    rem_fix;
   logic [REM_W-1:0]    rem_ff, rem_in;
   flags_type           flags_ff;

   assign prod      = PROD_W'(shown) * PROD_W'(HOUR_RECIP);
   assign quot_full = prod >> HOUR_RECIP_SHIFT;
   assign quot      = quot_full[QUOT_W-1:0];
   assign quot_ext  = MUL_W'(quot);
   // 3600 = 4096 - 512 + 16
   assign hours_secs = (quot_ext << 12) - (quot_ext << 9) + (quot_ext << 4);
   assign rem_raw    = MUL_W'(shown) - hours_secs;
   assign rem_fix    = (rem_raw >= MUL_W'(SECS_PER_HOUR)) ?
                       rem_raw - MUL_W'(SECS_PER_HOUR) : rem_raw;
   assign rem_in     = rem_fix[REM_W-1:0];

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff   <= rem_in;
         flags_ff <= flags;
      end
   end

   assign rem       = rem_ff;
   assign flags_out = flags_ff;

endmodule

`default_nettype wire

// File: hdl/ecc_minsec.sv
// Pipeline stage: splits seconds within the hour into minutes and seconds.
// Depends on ecc_pkg; drives the result register.
`default_nettype none

module ecc_minsec (
   input  logic                           clock,
   input  logic                           load,
   input  logic [ecc_pkg::REM_W-1:0]      rem,
   input  ecc_pkg::flags_type             flags,
   output logic [ecc_pkg::MINSEC_W-1:0]   minutes,
   output logic [ecc_pkg::MINSEC_W-1:0]   seconds,
   output ecc_pkg::flags_type             flags_out
);
   import ecc_pkg::*;

   localparam int PROD_W = REM_W + MIN_RECIP_W;

   logic [PROD_W-1:0]    prod;
   logic [PROD_W-1:0]    min_full;
   logic [MINSEC_W-1:0]  min_in;
   logic [REM_W-1:0]     min_ext;
   logic [REM_W-1:0]     min_secs;
   logic [REM_W-1:0]     sec_full;
   logic [MINSEC_W-1:0]  sec_in;
   logic [MINSEC_W-1:0]  minutes_ff;
   logic [MINSEC_W-1:0]  seconds_ff;
   flags_type            flags_ff;

   assign prod     = PROD_W'(rem) * PROD_W'(MIN_RECIP);
   assign min_full = prod >> MIN_RECIP_SHIFT;
   assign min_in   = min_full[MINSEC_W-1:0];
   assign min_ext  = REM_W'(min_in);
   // 60 = 64 - 4
   assign min_secs = (min_ext << 6) - (min_ext << 2);
   assign sec_full = rem - min_secs;
   assign sec_in   = sec_full[MINSEC_W-1:0];

   always_ff @(posedge clock) begin
      if (load) begin
         minutes_ff <= min_in;
         seconds_ff <= sec_in;
         flags_ff   <= flags;
      end
   end

   assign minutes   = minutes_ff;
   assign seconds   = seconds_ff;
   assign flags_out = flags_ff;

endmodule

`default_nettype wire
